@@ design/ascii_chained_divide_parser_assert.svh @@
// Assertion macros for the chained divide parser.
// Used by the controller; expects clock and reset in scope.
`ifndef ASCII_CHAINED_DIVIDE_PARSER_ASSERT_SVH
`define ASCII_CHAINED_DIVIDE_PARSER_ASSERT_SVH

// same-cycle implication
`define ACDP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ACDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/acdp_pkg.sv @@
// Shared types and constants for the chained divide parser.
// No dependencies; imported by every module of the block.
package acdp_pkg;

   localparam int ACC_BITS  = 32;
   localparam int QUOT_BITS = 32;
   localparam int WIDE_BITS = (ACC_BITS > QUOT_BITS) ? ACC_BITS : QUOT_BITS;
   localparam int CNT_BITS  = $clog2(ACC_BITS);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [3:0] RADIX      = 4'd10;

   typedef logic [ACC_BITS-1:0] acc_type;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_DIVISOR,
      PH_LF_FIRST,
      PH_LF_DIVISOR,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic acc_first;
      logic acc_div;
      logic div_start;
      logic div_commit;
      logic emit_load;
      logic emit_error;
      logic line_clear;
   } cmd_type;

   typedef struct packed {
      logic is_digit;
      logic is_space;
      logic is_cr;
      logic is_lf;
      logic div_zero;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ design/acdp_divider.sv @@
// Iterative restoring signed divider, one quotient bit per cycle.
// Depends on acdp_pkg.
module acdp_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  acdp_pkg::acc_type dividend,
   input  acdp_pkg::acc_type divisor,
   output logic             done,
   output acdp_pkg::acc_type quotient
);
   import acdp_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   acc_type             rem_ff, rem_in;
   acc_type             quo_ff, quo_in;
   acc_type             mb_ff;
   logic                neg_ff;
   logic [ACC_BITS:0]   trial;
   logic                fits;
   acc_type             mag_a, mag_b;

   always_comb begin
      mag_a  = dividend[ACC_BITS-1] ? (~dividend + 1'b1) : dividend;
      mag_b  = divisor[ACC_BITS-1] ? (~divisor + 1'b1) : divisor;
      trial  = {rem_ff, quo_ff[ACC_BITS-1]};
      fits   = trial >= {1'b0, mb_ff};
      rem_in = fits ? ACC_BITS'(trial - {1'b0, mb_ff}) : trial[ACC_BITS-1:0];
      quo_in = {quo_ff[ACC_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(ACC_BITS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= mag_a;
         mb_ff  <= mag_b;
         neg_ff <= dividend[ACC_BITS-1] ^ divisor[ACC_BITS-1];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

@@ design/acdp_datapath.sv @@
// Datapath: character decode, accumulators, divider and output register.
// Depends on acdp_pkg and acdp_divider.
module acdp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_char_in,
   input  logic                  rsp_stall,
   input  acdp_pkg::cmd_type     cmd,
   output acdp_pkg::status_type  status,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_quotient,
   output logic                  rsp_status
);
   import acdp_pkg::*;

   acc_type              running_ff, running_in;
   acc_type              divisor_ff, divisor_in;
   logic [3:0]           digit;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_quotient_ff;
   logic                 rsp_status_ff;
   logic [WIDE_BITS-1:0] wide_run;
   logic                 div_done;
   acc_type              div_quot;

   acdp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (running_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      digit           = 4'(req_char_in - CHAR_ZERO);
      status.is_digit = req_char_in inside {[CHAR_ZERO:CHAR_NINE]};
      status.is_space = req_char_in == CHAR_SPACE;
      status.is_cr    = req_char_in == CHAR_CR;
      status.is_lf    = req_char_in == CHAR_LF;
      status.div_zero = divisor_ff == '0;
      status.div_done = div_done;
      status.out_free = !rsp_valid_ff || !rsp_stall;
      wide_run        = WIDE_BITS'(running_ff);

      running_in = running_ff;
      divisor_in = divisor_ff;
      if (cmd.acc_first) begin
         running_in = (running_ff << 3) + (running_ff << 1) + ACC_BITS'(digit);
      end
      if (cmd.acc_div) begin
         divisor_in = (divisor_ff << 3) + (divisor_ff << 1) + ACC_BITS'(digit);
      end
      if (cmd.div_commit) begin
         running_in = div_quot;
         divisor_in = '0;
      end
      if (cmd.line_clear) begin
         running_in = '0;
         divisor_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         divisor_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
         divisor_ff <= divisor_in;
         if (cmd.emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_quotient_ff <= cmd.emit_error ? '0 : wide_run[31:0];
         rsp_status_ff   <= cmd.emit_error;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quotient = signed'(rsp_quotient_ff);
   assign rsp_status   = rsp_status_ff;

endmodule

@@ design/acdp_ctrl.sv @@
// Controller: parse phase and sequencing of accept, divide and emit.
// Depends on acdp_pkg and the assertion macro header.
`include "ascii_chained_divide_parser_assert.svh"
module acdp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  acdp_pkg::status_type status,
   output acdp_pkg::cmd_type    cmd
);
   import acdp_pkg::*;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           take;

   assign take = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (phase_ff)
                  PH_FIRST: begin
                     if (status.is_space) begin
                        phase_in = PH_DIVISOR;
                     end else if (status.is_cr) begin
                        phase_in = PH_LF_FIRST;
                     end else if (!status.is_digit) begin
                        phase_in = PH_ERROR;
                        state_in = ST_EMIT;
                     end
                  end
                  PH_DIVISOR: begin
                     if (status.is_space) begin
                        if (status.div_zero) begin
                           phase_in = PH_ERROR;
                           state_in = ST_EMIT;
                        end else begin
                           state_in = ST_DIVIDE;
                        end
                     end else if (status.is_cr) begin
                        phase_in = PH_LF_DIVISOR;
                     end else if (!status.is_digit) begin
                        phase_in = PH_ERROR;
                        state_in = ST_EMIT;
                     end
                  end
                  PH_LF_FIRST: begin
                     state_in = ST_EMIT;
                     if (!status.is_lf) begin
                        phase_in = PH_ERROR;
                     end
                  end
                  PH_LF_DIVISOR: begin
                     if (status.is_lf && !status.div_zero) begin
                        state_in = ST_DIVIDE;
                     end else begin
                        phase_in = PH_ERROR;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     phase_in = PH_ERROR;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = (phase_ff == PH_LF_DIVISOR) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
               if (phase_ff != PH_ERROR) begin
                  phase_in = PH_FIRST;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.acc_first = (phase_ff == PH_FIRST) && status.is_digit;
               cmd.acc_div   = (phase_ff == PH_DIVISOR) && status.is_digit;
               cmd.div_start = (phase_ff == PH_DIVISOR && status.is_space
                                && !status.div_zero)
                               || (phase_ff == PH_LF_DIVISOR && status.is_lf
                                   && !status.div_zero);
            end
         end
         ST_DIVIDE: begin
            cmd.div_commit = status.div_done;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load  = 1'b1;
               cmd.emit_error = phase_ff == PH_ERROR;
               cmd.line_clear = phase_ff != PH_ERROR;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FIRST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   `ACDP_ASSERT_NOW(a_divide_phase, state_ff == ST_DIVIDE, phase_ff == PH_DIVISOR || phase_ff == PH_LF_DIVISOR, "divide outside a divisor phase")
   `ACDP_ASSERT_NOW(a_done_in_divide, status.div_done, state_ff == ST_DIVIDE, "divider done while not dividing")
   `ACDP_ASSERT_NOW(a_emit_slot, cmd.emit_load, status.out_free, "result loaded over a pending result")
   `ACDP_ASSERT_NEXT(a_error_sticks, phase_ff == PH_ERROR, phase_ff == PH_ERROR, "error phase left without reset")

endmodule

@@ design/ascii_chained_divide_parser.sv @@
// Top level of the ASCII chained divide parser.
// Depends on acdp_pkg, acdp_ctrl and acdp_datapath.
//
// Input channel req_*: one ASCII byte per transaction on req_char_in, taken
// when req_valid is high and req_stall is low. Lines are decimal numbers
// separated by single spaces and ended by CR LF.
// Result channel rsp_*: one transaction per completed line (rsp_status 0,
// rsp_quotient the first number divided in turn by each later one) or one
// per detected error (rsp_status 1, rsp_quotient 0); after an error, bytes
// are taken and dropped until reset.
// A digit, CR or plain separator is taken without a stall. A space after a
// divisor stalls input through the divide state, the divider producing one
// quotient bit per cycle over 32 bits. An LF stalls input through the emit
// state, after a divisor through divide and then emit. Results are loaded
// into an output register from the emit state; the next byte is taken while
// that result waits. If rsp_stall holds a result, a following line end or
// error waits before it is loaded. Reset is synchronous and active high; it
// clears the accumulators, drops any pending result and starts a new line.
module ascii_chained_divide_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_quotient,
   output logic               rsp_status
);
   import acdp_pkg::*;

   cmd_type    cmd;
   status_type status;

   acdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   acdp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_char_in  (req_char_in),
      .rsp_stall    (rsp_stall),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_quotient (rsp_quotient),
      .rsp_status   (rsp_status)
   );

endmodule
